### hw/rtl/kli_pkg.sv
// Shared types and constants for the keyframe light interpolator.
package kli_pkg;

  localparam int TimeBits = 31;

  // Request function codes
  localparam logic [2:0] FN_SET_TIME = 3'd0;
  localparam logic [2:0] FN_SET_LAMP = 3'd1;
  localparam logic [2:0] FN_CLEAR    = 3'd2;
  localparam logic [2:0] FN_START    = 3'd3;
  localparam logic [2:0] FN_QUERY    = 3'd4;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_SCAN_RD  = 13'b0000000000010,
    S_SCAN_CMP = 13'b0000000000100,
    S_DECIDE   = 13'b0000000001000,
    S_LSEL     = 13'b0000000010000,
    S_EMPTY    = 13'b0000000100000,
    S_RD_A     = 13'b0000001000000,
    S_RD_B     = 13'b0000010000000,
    S_MUL_A    = 13'b0000100000000,
    S_MUL_B    = 13'b0001000000000,
    S_SUM      = 13'b0010000000000,
    S_DIV      = 13'b0100000000000,
    S_OUT      = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic scan_cmp;
    logic decide;
    logic rd_a;
    logic rd_b;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic div_step;
    logic take;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic rem_empty;
    logic sent_any;
    logic div_last;
  } status_t;

endpackage

### hw/rtl/kli_if.sv
// Request and result channel interfaces.
interface kli_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [3:0]  slot;
  logic [30:0] key_time;
  logic [3:0]  lamp_id;
  logic [15:0] lamp_level;
  logic [30:0] query_time;

  modport source (output valid, func, slot, key_time, lamp_id, lamp_level, query_time,
                  input ready);
  modport sink (input valid, func, slot, key_time, lamp_id, lamp_level, query_time,
                output ready);
endinterface

interface kli_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_lamp;
  logic [15:0] out_level;
  logic        out_valid;
  logic        exit_requested;
  logic        last;

  modport source (output valid, out_lamp, out_level, out_valid, exit_requested, last,
                  input ready);
  modport sink (input valid, out_lamp, out_level, out_valid, exit_requested, last,
                output ready);
endinterface

### hw/rtl/keyframe_light_interpolator.sv
// Keyframe light interpolator: state machine, datapath and channel hookup.
// Write requests (set time, set lamp, clear, start) are accepted in S_IDLE.
// A query scans the slots (a read and a compare per slot), then for each lamp
// reads two levels, does two multiplies, a sum and a one-bit-per-cycle divide,
// then waits for the result to be taken; one request is in work at a time.
// Synchronous reset clears slot valid and lamp present bits, exit flag and auto_exit.
module keyframe_light_interpolator
  import kli_pkg::*;
#(
  parameter int NUM_KEYS   = 16,
  parameter int NUM_LAMPS  = 16,
  parameter int LEVEL_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  kli_req_if.sink   req,
  kli_res_if.source res
);

  cmd_t    cmd;
  status_t st;

  kli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .st        (st),
    .cmd       (cmd)
  );

  kli_dp #(
    .NUM_KEYS   (NUM_KEYS),
    .NUM_LAMPS  (NUM_LAMPS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .st             (st),
    .func           (req.func),
    .slot           (req.slot),
    .key_time       (req.key_time),
    .lamp_id        (req.lamp_id),
    .lamp_level     (req.lamp_level),
    .query_time     (req.query_time),
    .out_lamp       (res.out_lamp),
    .out_level      (res.out_level),
    .out_valid      (res.out_valid),
    .exit_requested (res.exit_requested),
    .last           (res.last)
  );

endmodule

### hw/rtl/kli_ctrl.sv
// Controller state machine for the keyframe light interpolator.
module kli_ctrl
  import kli_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [2:0] req_func,
  output logic       req_ready,
  output logic       res_valid,
  input  logic       res_ready,
  input  status_t    st,
  output cmd_t       cmd
);

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT) || (state == S_EMPTY);

  // Decode commands from the current state
  always_comb begin
    cmd            = '0;
    cmd.accept     = req_valid && req_ready;
    cmd.scan_rd    = (state == S_SCAN_RD);
    cmd.scan_cmp   = (state == S_SCAN_CMP);
    cmd.decide     = (state == S_DECIDE);
    cmd.rd_a       = (state == S_RD_A);
    cmd.rd_b       = (state == S_RD_B);
    cmd.mul_a      = (state == S_MUL_A);
    cmd.mul_b      = (state == S_MUL_B);
    cmd.sum        = (state == S_SUM);
    cmd.div_step   = (state == S_DIV);
    cmd.take       = (state == S_OUT) && res_ready;
    cmd.emit_empty = (state == S_EMPTY);
  end

  // Advance through scan, lamp selection and divide
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid && req_func == FN_QUERY) state_next = S_SCAN_RD;
      end
      S_SCAN_RD:  state_next = S_SCAN_CMP;
      S_SCAN_CMP: state_next = st.scan_last ? S_DECIDE : S_SCAN_RD;
      S_DECIDE:   state_next = S_LSEL;
      S_LSEL: begin
        if (!st.rem_empty) state_next = S_RD_A;
        else if (st.sent_any) state_next = S_IDLE;
        else state_next = S_EMPTY;
      end
      S_EMPTY: begin
        if (res_ready) state_next = S_IDLE;
      end
      S_RD_A:  state_next = S_RD_B;
      S_RD_B:  state_next = S_MUL_A;
      S_MUL_A: state_next = S_MUL_B;
      S_MUL_B: state_next = S_SUM;
      S_SUM:   state_next = S_DIV;
      S_DIV: begin
        if (st.div_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (res_ready) state_next = S_LSEL;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

### hw/rtl/kli_dp.sv
// Datapath: keyframe storage, scan, multiply and restoring divide.
module kli_dp
  import kli_pkg::*;
#(
  parameter int NUM_KEYS   = 16,
  parameter int NUM_LAMPS  = 16,
  parameter int LEVEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  cmd_t        cmd,
  output status_t     st,
  input  logic [2:0]  func,
  input  logic [3:0]  slot,
  input  logic [30:0] key_time,
  input  logic [3:0]  lamp_id,
  input  logic [15:0] lamp_level,
  input  logic [30:0] query_time,
  output logic [3:0]  out_lamp,
  output logic [15:0] out_level,
  output logic        out_valid,
  output logic        exit_requested,
  output logic        last
);

  localparam int TW  = TimeBits;
  localparam int LW  = LEVEL_BITS;
  localparam int SW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int AW  = (NUM_LAMPS > 1) ? $clog2(NUM_LAMPS) : 1;
  localparam int NW  = LW + TW + 1;
  localparam int CW  = $clog2(LW);

  // Keyframe storage
  logic [NUM_KEYS-1:0]  slot_valid;
  logic [NUM_LAMPS-1:0] present [NUM_KEYS];
  logic [TW-1:0]        time_mem [NUM_KEYS];
  logic [LW-1:0]        level_mem [NUM_KEYS][NUM_LAMPS];

  logic          auto_exit;
  logic          exit_flag;
  logic [TW-1:0] q_time;

  // Scan state
  logic [SW-1:0]        sidx;
  logic [TW-1:0]        t_rd;
  logic                 has_prev, has_next;
  logic [TW-1:0]        tp, tn;
  logic [SW-1:0]        pidx, nidx;
  logic [NUM_LAMPS-1:0] pset, nset, uset;

  // Lamp loop state
  logic [NUM_LAMPS-1:0] rem, amask, bmask;
  logic [SW-1:0]        aslot, bslot;
  logic [TW-1:0]        d, m;
  logic                 sent;
  logic [AW-1:0]        lcur, llow;
  logic [LW-1:0]        lv_rd, a_val, b_val;
  logic [LW+TW-1:0]     prod1, prod2;
  logic [TW-1:0]        r;
  logic [LW-1:0]        qlo;
  logic [CW-1:0]        cnt;

  logic                 slot_ok, lamp_ok;
  logic [SW-1:0]        wslot;
  logic [AW-1:0]        wlamp;
  logic [NW-1:0]        sum_w;
  logic [TW:0]          dtrial;
  logic [TW:0]          dsub;
  logic [NUM_LAMPS-1:0] rem_after;

  assign slot_ok = (32'(slot) < NUM_KEYS);
  assign lamp_ok = (32'(lamp_id) < NUM_LAMPS);
  assign wslot   = SW'(slot);
  assign wlamp   = AW'(lamp_id);

  // Pick the lowest lamp still to be sent
  always_comb begin
    llow = '0;
    for (int i = NUM_LAMPS - 1; i >= 0; i--) begin
      if (rem[i]) llow = AW'(i);
    end
  end

  assign sum_w  = NW'(prod1) + NW'(prod2) + NW'(d >> 1);
  assign dtrial = {r, qlo[LW-1]};
  assign dsub   = dtrial - {1'b0, d};
  assign rem_after = rem & ~(NUM_LAMPS'(1) << lcur);

  assign st.scan_last = (sidx == SW'(NUM_KEYS - 1));
  assign st.rem_empty = (rem == '0);
  assign st.sent_any  = sent;
  assign st.div_last  = (cnt == CW'(LW - 1));

  // Configuration and exit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_exit <= 1'b0;
      exit_flag <= 1'b0;
    end else begin
      if (cfg_we) auto_exit <= cfg_wdata;
      if (cmd.accept && func == FN_START) exit_flag <= 1'b0;
      if (cmd.decide && has_prev && !has_next && auto_exit) exit_flag <= 1'b1;
    end
  end

  // Valid and present bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      for (int k = 0; k < NUM_KEYS; k++) present[k] <= '0;
    end else if (cmd.accept) begin
      case (func)
        FN_SET_TIME: begin
          if (slot_ok) begin
            slot_valid[wslot] <= 1'b1;
            present[wslot]    <= '0;
          end
        end
        FN_SET_LAMP: begin
          if (slot_ok && lamp_ok) present[wslot][wlamp] <= 1'b1;
        end
        FN_CLEAR: begin
          slot_valid <= '0;
          for (int k = 0; k < NUM_KEYS; k++) present[k] <= '0;
        end
        default: ;
      endcase
    end
  end

  // Time memory: write on set time, read during scan
  always_ff @(posedge clk) begin
    if (cmd.accept && func == FN_SET_TIME && slot_ok) time_mem[wslot] <= key_time;
    if (cmd.scan_rd) t_rd <= time_mem[sidx];
  end

  // Level memory: write on set lamp, read one port per cycle
  always_ff @(posedge clk) begin
    if (cmd.accept && func == FN_SET_LAMP && slot_ok && lamp_ok) begin
      level_mem[wslot][wlamp] <= LW'(lamp_level);
    end
    if (cmd.rd_a) lv_rd <= level_mem[aslot][llow];
    else if (cmd.rd_b) lv_rd <= level_mem[bslot][lcur];
  end

  // Scan slots for previous and next keyframes
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q_time   <= query_time;
      sidx     <= '0;
      has_prev <= 1'b0;
      has_next <= 1'b0;
      uset     <= '0;
    end else if (cmd.scan_cmp) begin
      if (slot_valid[sidx]) begin
        uset <= uset | present[sidx];
        if (t_rd <= q_time) begin
          if (!has_prev || t_rd > tp) begin
            has_prev <= 1'b1;
            tp       <= t_rd;
            pidx     <= sidx;
            pset     <= present[sidx];
          end
        end else begin
          if (!has_next || t_rd < tn) begin
            has_next <= 1'b1;
            tn       <= t_rd;
            nidx     <= sidx;
            nset     <= present[sidx];
          end
        end
      end
      sidx <= sidx + SW'(1);
    end
  end

  // Choose lamp set, source slots and interpolation span
  always_ff @(posedge clk) begin
    if (rst) begin
      rem  <= '0;
      sent <= 1'b0;
    end else if (cmd.decide) begin
      sent  <= 1'b0;
      d     <= TW'(1);
      m     <= '0;
      bmask <= '0;
      if (has_prev && has_next) begin
        rem   <= uset;
        aslot <= pidx;
        bslot <= nidx;
        amask <= pset;
        bmask <= nset;
        d     <= tn - tp;
        m     <= q_time - tp;
      end else if (has_prev) begin
        rem   <= pset;
        aslot <= pidx;
        bslot <= pidx;
        amask <= pset;
      end else if (has_next) begin
        rem   <= nset;
        aslot <= nidx;
        bslot <= nidx;
        amask <= nset;
      end else begin
        rem <= '0;
      end
    end else if (cmd.take) begin
      rem  <= rem_after;
      sent <= 1'b1;
    end
  end

  // Gather levels, multiply, sum and divide
  always_ff @(posedge clk) begin
    if (cmd.rd_a) lcur <= llow;
    if (cmd.rd_b) a_val <= amask[lcur] ? lv_rd : '0;
    if (cmd.mul_a) begin
      b_val <= bmask[lcur] ? lv_rd : '0;
      prod1 <= (LW+TW)'(a_val) * (LW+TW)'(d - m);
    end
    if (cmd.mul_b) prod2 <= (LW+TW)'(b_val) * (LW+TW)'(m);
    if (cmd.sum) begin
      r   <= TW'(sum_w >> LW);
      qlo <= sum_w[LW-1:0];
      cnt <= '0;
    end
    if (cmd.div_step) begin
      if (!dsub[TW]) begin
        r   <= dsub[TW-1:0];
        qlo <= {qlo[LW-2:0], 1'b1};
      end else begin
        r   <= dtrial[TW-1:0];
        qlo <= {qlo[LW-2:0], 1'b0};
      end
      cnt <= cnt + CW'(1);
    end
  end

  // Result payload
  assign out_valid      = !cmd.emit_empty;
  assign out_lamp       = cmd.emit_empty ? 4'd0 : 4'(lcur);
  assign out_level      = cmd.emit_empty ? 16'd0 : 16'(qlo);
  assign last           = cmd.emit_empty ? 1'b1 : (rem_after == '0);
  assign exit_requested = exit_flag;

endmodule
